// File: rtl/pidpl_pkg.sv
// Shared types, register indexes and constants of the position PID loop.
`default_nettype none

package pidpl_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Operand and result widths of the shared fixed-point multiply unit.
    localparam int MUL_A_W   = 64;
    localparam int MUL_B_W   = 32;
    localparam int MUL_RES_W = 62;
    localparam int MAG_W     = 61;

    // Every fixed-point product magnitude saturates at 2^60.
    localparam logic [MAG_W-1:0] TERM_LIMIT = MAG_W'(1) << 60;

    localparam logic [30:0] MM_PER_PULSE_RST = 31'd65536;
    localparam logic [16:0] SAMPLE_PERIOD_RST = 17'd66;
    localparam logic [30:0] INV_PERIOD_RST = 31'd65536000;
    localparam logic [6:0]  SPEED_SCALE_RST = 7'd100;
    localparam logic [6:0]  DUTY_FULL = 7'd100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_MM_PER_PULSE  = 3'd3,
        REG_SAMPLE_PERIOD = 3'd4,
        REG_INV_PERIOD    = 3'd5,
        REG_SPEED_SCALE   = 3'd6,
        REG_TOLERANCE     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [15:0] encoder_delta;
        logic signed [31:0] setpoint;
    } in_item_t;

    typedef struct packed {
        logic [6:0]         compare_value;
        logic               direction;
        logic               finished;
        logic signed [31:0] position;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_ISSUE,
        ST_WAIT,
        ST_POST,
        ST_DRIVE,
        ST_OUT
    } state_t;

    // Multiplies of one sample, in the order the sequencer runs them.
    typedef enum logic [2:0] {
        OP_ERR_SCALE,
        OP_INTEGRAL,
        OP_PROP,
        OP_INTEG_TERM,
        OP_DERIV_RATE,
        OP_DERIV_TERM,
        OP_DUTY
    } op_t;

    typedef struct packed {
        logic               start;
        logic               neg;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [MUL_RES_W-1:0] product;
    } mul_rsp_t;

endpackage

`default_nettype wire

// File: rtl/pidpl_mul.sv
// Shared fixed-point multiply unit: magnitude product, shift, saturate and sign.
`default_nettype none

module pidpl_mul #(
    parameter int FRACTION_BITS = pidpl_pkg::FRACTION_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pidpl_pkg::mul_req_t req,
    output pidpl_pkg::mul_rsp_t      rsp
);

    localparam int AW = pidpl_pkg::MUL_A_W;
    localparam int BW = pidpl_pkg::MUL_B_W;
    localparam int PW = AW + BW;
    localparam int MW = pidpl_pkg::MAG_W;
    localparam int RW = pidpl_pkg::MUL_RES_W;
    localparam int HW = AW / 2;

    logic [AW-1:0]  a_reg, a_next;
    logic [BW-1:0]  b_reg, b_next;
    logic           neg_reg, neg_next;
    logic           busy_reg, busy_next;
    logic [1:0]     step_reg, step_next;
    logic [63:0]    part_reg, part_next;
    logic [63:0]    lo_reg, lo_next;
    logic [MW-1:0]  mag_reg, mag_next;
    logic [RW-1:0]  result_reg, result_next;
    logic           done_reg, done_next;
    logic [PW-1:0]  full;
    logic [PW-1:0]  shifted;
    logic [HW-1:0]  mul_op;
    logic [63:0]    mul_out;

    // One 32 by 32 multiplier forms the low and then the high partial product.
    assign mul_op  = (step_reg == 2'd0) ? a_reg[HW-1:0] : a_reg[AW-1:HW];
    assign mul_out = 64'(mul_op) * 64'(b_reg);

    // The 64 by 32 product is built from two 32 by 32 partial products.
    assign full    = {part_reg, {HW{1'b0}}} + {{HW{1'b0}}, lo_reg};
    assign shifted = full >> FRACTION_BITS;

    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        neg_next    = neg_reg;
        busy_next   = busy_reg;
        step_next   = step_reg;
        part_next   = part_reg;
        lo_next     = lo_reg;
        mag_next    = mag_reg;
        result_next = result_reg;
        done_next   = 1'b0;

        if (!busy_reg)
        begin
            if (req.start)
            begin
                a_next    = req.a;
                b_next    = req.b;
                neg_next  = req.neg;
                busy_next = 1'b1;
                step_next = 2'd0;
            end
        end
        else
        begin
            case (step_reg)
                2'd0:
                begin
                    part_next = mul_out;
                    step_next = 2'd1;
                end
                2'd1:
                begin
                    part_next = mul_out;
                    lo_next   = part_reg;
                    step_next = 2'd2;
                end
                2'd2:
                begin
                    if (shifted > PW'(pidpl_pkg::TERM_LIMIT))
                        mag_next = pidpl_pkg::TERM_LIMIT;
                    else
                        mag_next = shifted[MW-1:0];
                    step_next = 2'd3;
                end
                default:
                begin
                    if (neg_reg)
                        result_next = ~{1'b0, mag_reg} + RW'(1);
                    else
                        result_next = {1'b0, mag_reg};
                    done_next = 1'b1;
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg      <= '0;
            b_reg      <= '0;
            neg_reg    <= 1'b0;
            busy_reg   <= 1'b0;
            step_reg   <= 2'd0;
            part_reg   <= '0;
            lo_reg     <= '0;
            mag_reg    <= '0;
            result_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            a_reg      <= a_next;
            b_reg      <= b_next;
            neg_reg    <= neg_next;
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            part_reg   <= part_next;
            lo_reg     <= lo_next;
            mag_reg    <= mag_next;
            result_reg <= result_next;
            done_reg   <= done_next;
        end
    end

    assign rsp = {done_reg, result_reg};

endmodule

`default_nettype wire

// File: rtl/pid_position_loop.sv
// Top level of the position PID loop: registers, sequencer and output stage.
`default_nettype none

// Each accepted sample adds the encoder delta to the position, scales the pulse
// error to fixed point, updates the saturating integral and forms the clamped
// PID drive, which becomes a PWM compare value and a direction bit. All seven
// fixed-point products of a sample run one after another through a single
// shared multiply unit built around one 32 by 32 multiplier, so a new sample
// is taken only after the previous one has been written to the output register;
// in_stall stays high while a sample is in work. A finished result
// waits in the output register and does not block the next sample's work
// until the sequencer needs to write its own result.

module pid_position_loop #(
    parameter int FRACTION_BITS = pidpl_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire pidpl_pkg::in_item_t                  in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output pidpl_pkg::out_item_t                      out_data,
    input  wire logic                                 cfg_write_en,
    input  wire logic [pidpl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [pidpl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DW = FRACTION_BITS + 2;
    localparam int RW = pidpl_pkg::MUL_RES_W;
    localparam int SW = RW + 1;
    localparam logic signed [SW-1:0] ONE     = SW'(1) <<< FRACTION_BITS;
    localparam logic signed [SW-1:0] NEG_ONE = -ONE;
    localparam logic signed [SW-1:0] INT_HI  = (SW'(1) <<< 47) - SW'(1);
    localparam logic signed [SW-1:0] INT_LO  = -(SW'(1) <<< 47);
    localparam logic signed [RW-1:0] EMM_HI  = (RW'(1) <<< 31) - RW'(1);
    localparam logic signed [RW-1:0] EMM_LO  = -(RW'(1) <<< 31);

    // Configuration registers.
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [30:0]        mm_per_pulse_reg;
    logic [16:0]        sample_period_reg;
    logic [30:0]        inv_period_reg;
    logic [6:0]         speed_scale_reg;
    logic [7:0]         tolerance_reg;

    // Sequencer and loop state.
    pidpl_pkg::state_t      state_reg, state_next;
    pidpl_pkg::op_t         op_reg, op_next;
    logic signed [31:0]     pos_reg, pos_next;
    logic signed [31:0]     sp_reg, sp_next;
    logic signed [32:0]     err_reg, err_next;
    logic signed [31:0]     emm_reg, emm_next;
    logic signed [47:0]     integ_reg, integ_next;
    logic signed [31:0]     prev_reg, prev_next;
    logic signed [32:0]     diff_reg, diff_next;
    logic signed [RW-1:0]   dterm_reg, dterm_next;
    logic signed [SW-1:0]   sum_reg, sum_next;
    logic signed [DW-1:0]   drive_reg, drive_next;
    logic                   fin_reg, fin_next;
    logic [6:0]             mag_reg, mag_next;
    logic                   out_valid_reg, out_valid_next;
    pidpl_pkg::out_item_t   out_data_reg, out_data_next;

    pidpl_pkg::mul_req_t    mul_req;
    pidpl_pkg::mul_rsp_t    mul_rsp;

    logic [32:0]            err_abs;
    logic [31:0]            emm_abs;
    logic [47:0]            integ_abs;
    logic [32:0]            diff_abs;
    logic [RW-1:0]          dterm_abs;
    logic [DW-1:0]          drive_abs;
    logic [31:0]            gain_p_abs, gain_i_abs, gain_d_abs;
    logic [6:0]             speed_lim;
    logic signed [RW-1:0]   res;
    logic signed [SW-1:0]   integ_sum;

    assign err_abs    = err_reg[32] ? 33'(-err_reg) : 33'(err_reg);
    assign emm_abs    = emm_reg[31] ? 32'(-emm_reg) : 32'(emm_reg);
    assign integ_abs  = integ_reg[47] ? 48'(-integ_reg) : 48'(integ_reg);
    assign diff_abs   = diff_reg[32] ? 33'(-diff_reg) : 33'(diff_reg);
    assign dterm_abs  = dterm_reg[RW-1] ? RW'(-dterm_reg) : RW'(dterm_reg);
    assign drive_abs  = drive_reg[DW-1] ? DW'(-drive_reg) : DW'(drive_reg);
    assign gain_p_abs = gain_p_reg[31] ? 32'(-gain_p_reg) : 32'(gain_p_reg);
    assign gain_i_abs = gain_i_reg[31] ? 32'(-gain_i_reg) : 32'(gain_i_reg);
    assign gain_d_abs = gain_d_reg[31] ? 32'(-gain_d_reg) : 32'(gain_d_reg);
    assign speed_lim  = (speed_scale_reg > pidpl_pkg::DUTY_FULL) ?
                        pidpl_pkg::DUTY_FULL : speed_scale_reg;
    assign res        = $signed(mul_rsp.product);
    assign integ_sum  = {{(SW-48){integ_reg[47]}}, integ_reg} + {res[RW-1], res};

    pidpl_mul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg        <= '0;
            gain_i_reg        <= '0;
            gain_d_reg        <= '0;
            mm_per_pulse_reg  <= pidpl_pkg::MM_PER_PULSE_RST;
            sample_period_reg <= pidpl_pkg::SAMPLE_PERIOD_RST;
            inv_period_reg    <= pidpl_pkg::INV_PERIOD_RST;
            speed_scale_reg   <= pidpl_pkg::SPEED_SCALE_RST;
            tolerance_reg     <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (pidpl_pkg::cfg_reg_t'(cfg_index))
                pidpl_pkg::REG_GAIN_P:        gain_p_reg        <= $signed(cfg_data);
                pidpl_pkg::REG_GAIN_I:        gain_i_reg        <= $signed(cfg_data);
                pidpl_pkg::REG_GAIN_D:        gain_d_reg        <= $signed(cfg_data);
                pidpl_pkg::REG_MM_PER_PULSE:  mm_per_pulse_reg  <= cfg_data[30:0];
                pidpl_pkg::REG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[16:0];
                pidpl_pkg::REG_INV_PERIOD:    inv_period_reg    <= cfg_data[30:0];
                pidpl_pkg::REG_SPEED_SCALE:   speed_scale_reg   <= cfg_data[6:0];
                pidpl_pkg::REG_TOLERANCE:     tolerance_reg     <= cfg_data[7:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        sp_next        = sp_reg;
        err_next       = err_reg;
        emm_next       = emm_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        diff_next      = diff_reg;
        dterm_next     = dterm_reg;
        sum_next       = sum_reg;
        drive_next     = drive_reg;
        fin_next       = fin_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mul_req        = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            pidpl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    pos_next   = pos_reg + {{16{in_data.encoder_delta[15]}},
                                            in_data.encoder_delta};
                    sp_next    = in_data.setpoint;
                    state_next = pidpl_pkg::ST_ERR;
                end
            end

            pidpl_pkg::ST_ERR:
            begin
                err_next   = {sp_reg[31], sp_reg} - {pos_reg[31], pos_reg};
                op_next    = pidpl_pkg::OP_ERR_SCALE;
                state_next = pidpl_pkg::ST_ISSUE;
            end

            pidpl_pkg::ST_ISSUE:
            begin
                mul_req.start = 1'b1;
                unique case (op_reg)
                    pidpl_pkg::OP_ERR_SCALE:
                    begin
                        mul_req.a = 64'(err_abs);
                        mul_req.b = 32'(mm_per_pulse_reg);
                        mul_req.neg = err_reg[32];
                        fin_next = err_abs < 33'(tolerance_reg);
                    end
                    pidpl_pkg::OP_INTEGRAL:
                    begin
                        mul_req.a = 64'(emm_abs);
                        mul_req.b = 32'(sample_period_reg);
                        mul_req.neg = emm_reg[31];
                    end
                    pidpl_pkg::OP_PROP:
                    begin
                        mul_req.a = 64'(emm_abs);
                        mul_req.b = gain_p_abs;
                        mul_req.neg = gain_p_reg[31] ^ emm_reg[31];
                    end
                    pidpl_pkg::OP_INTEG_TERM:
                    begin
                        mul_req.a = 64'(integ_abs);
                        mul_req.b = gain_i_abs;
                        mul_req.neg = gain_i_reg[31] ^ integ_reg[47];
                    end
                    pidpl_pkg::OP_DERIV_RATE:
                    begin
                        mul_req.a = 64'(diff_abs);
                        mul_req.b = 32'(inv_period_reg);
                        mul_req.neg = diff_reg[32];
                    end
                    pidpl_pkg::OP_DERIV_TERM:
                    begin
                        mul_req.a = 64'(dterm_abs);
                        mul_req.b = gain_d_abs;
                        mul_req.neg = gain_d_reg[31] ^ dterm_reg[RW-1];
                    end
                    default:
                    begin
                        mul_req.a = 64'(drive_abs);
                        mul_req.b = 32'(speed_lim);
                        mul_req.neg = 1'b0;
                    end
                endcase
                state_next = pidpl_pkg::ST_WAIT;
            end

            pidpl_pkg::ST_WAIT:
            begin
                if (mul_rsp.done)
                    state_next = pidpl_pkg::ST_POST;
            end

            pidpl_pkg::ST_POST:
            begin
                state_next = pidpl_pkg::ST_ISSUE;
                unique case (op_reg)
                    pidpl_pkg::OP_ERR_SCALE:
                    begin
                        if (res > EMM_HI)
                            emm_next = EMM_HI[31:0];
                        else if (res < EMM_LO)
                            emm_next = EMM_LO[31:0];
                        else
                            emm_next = res[31:0];
                        op_next = pidpl_pkg::OP_INTEGRAL;
                    end
                    pidpl_pkg::OP_INTEGRAL:
                    begin
                        if (integ_sum > INT_HI)
                            integ_next = INT_HI[47:0];
                        else if (integ_sum < INT_LO)
                            integ_next = INT_LO[47:0];
                        else
                            integ_next = integ_sum[47:0];
                        diff_next = {emm_reg[31], emm_reg} - {prev_reg[31], prev_reg};
                        op_next   = pidpl_pkg::OP_PROP;
                    end
                    pidpl_pkg::OP_PROP:
                    begin
                        sum_next = {res[RW-1], res};
                        op_next  = pidpl_pkg::OP_INTEG_TERM;
                    end
                    pidpl_pkg::OP_INTEG_TERM:
                    begin
                        sum_next = sum_reg + {res[RW-1], res};
                        op_next  = pidpl_pkg::OP_DERIV_RATE;
                    end
                    pidpl_pkg::OP_DERIV_RATE:
                    begin
                        dterm_next = res;
                        op_next    = pidpl_pkg::OP_DERIV_TERM;
                    end
                    pidpl_pkg::OP_DERIV_TERM:
                    begin
                        sum_next   = sum_reg + {res[RW-1], res};
                        state_next = pidpl_pkg::ST_DRIVE;
                    end
                    default:
                    begin
                        mag_next   = res[6:0];
                        state_next = pidpl_pkg::ST_OUT;
                    end
                endcase
            end

            pidpl_pkg::ST_DRIVE:
            begin
                // Inside the tolerance band the drive is forced off and the
                // derivative history restarts from zero.
                if (fin_reg)
                    drive_next = '0;
                else if (sum_reg > ONE)
                    drive_next = ONE[DW-1:0];
                else if (sum_reg < NEG_ONE)
                    drive_next = NEG_ONE[DW-1:0];
                else
                    drive_next = sum_reg[DW-1:0];
                prev_next  = fin_reg ? 32'sd0 : emm_reg;
                op_next    = pidpl_pkg::OP_DUTY;
                state_next = pidpl_pkg::ST_ISSUE;
            end

            pidpl_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.finished = fin_reg;
                    out_data_next.position = pos_reg;
                    if (mag_reg == 7'd0)
                    begin
                        out_data_next.compare_value = 7'd0;
                        out_data_next.direction     = 1'b0;
                    end
                    else if (!drive_reg[DW-1])
                    begin
                        out_data_next.compare_value = pidpl_pkg::DUTY_FULL - mag_reg;
                        out_data_next.direction     = 1'b1;
                    end
                    else
                    begin
                        out_data_next.compare_value = mag_reg;
                        out_data_next.direction     = 1'b0;
                    end
                    state_next = pidpl_pkg::ST_IDLE;
                end
            end

            default:
                state_next = pidpl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pidpl_pkg::ST_IDLE;
            op_reg        <= pidpl_pkg::OP_ERR_SCALE;
            pos_reg       <= '0;
            sp_reg        <= '0;
            err_reg       <= '0;
            emm_reg       <= '0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            diff_reg      <= '0;
            dterm_reg     <= '0;
            sum_reg       <= '0;
            drive_reg     <= '0;
            fin_reg       <= 1'b0;
            mag_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            pos_reg       <= pos_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            emm_reg       <= emm_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
            diff_reg      <= diff_next;
            dterm_reg     <= dterm_next;
            sum_reg       <= sum_next;
            drive_reg     <= drive_next;
            fin_reg       <= fin_next;
            mag_reg       <= mag_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign in_stall  = (state_reg != pidpl_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
